@@ design/nbpg_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants of the pairwise gravity force block
// no dependencies

package nbpg_pkg;

  // field widths
  localparam int unsigned POS_W    = 32;
  localparam int unsigned MASS_W   = 32;
  localparam int unsigned G_W      = 16;
  localparam int unsigned IDX_W    = 6;
  localparam int unsigned FORCE_W  = 64;

  // arithmetic widths
  localparam int unsigned DIFF_W   = POS_W + 1;        // exact difference / magnitude
  localparam int unsigned GMI_W    = G_W + MASS_W;     // g * mi
  localparam int unsigned GMM_W    = GMI_W + MASS_W;   // g * mi * mj
  localparam int unsigned R2_W     = 2 * DIFF_W;       // dx^2 + dy^2
  localparam int unsigned ROOT_W   = DIFF_W;           // floor(sqrt(r2))
  localparam int unsigned DEN_W    = R2_W + ROOT_W;    // r2 * root
  localparam int unsigned QUO_W    = FORCE_W - 1;      // quotient bits below the clamp
  localparam int unsigned FRAC_SHIFT = 48;

  // shared shift-add multiplier
  localparam int unsigned MUL_A_W   = GMM_W;
  localparam int unsigned MUL_B_W   = ROOT_W + 1;
  localparam int unsigned MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int unsigned MUL_CNT_W = 6;

  // square root and divider
  localparam int unsigned SQ_REM_W  = ROOT_W + 3;
  localparam int unsigned SQ_CNT_W  = 6;
  localparam int unsigned DIV_N_W   = MUL_P_W + FRAC_SHIFT;
  localparam int unsigned DIV_CNT_W = 8;

  localparam logic [G_W-1:0]     G_RESET   = 16'd100;
  localparam logic [FORCE_W-1:0] FORCE_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [FORCE_W-1:0] FORCE_MIN = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
    logic [MASS_W-1:0] mass;
  } body_t;

  typedef struct packed {
    logic [FORCE_W-1:0] value;
    logic               sat;
  } acc_t;

  typedef enum logic [4:0] {
    S_LOAD,
    S_ROW_RD,
    S_ROW_DATA,
    S_GMI,
    S_PAIR_CHK,
    S_PAIR_DATA,
    S_DIFF,
    S_SQX,
    S_SQY,
    S_SQRT_GO,
    S_SQRT,
    S_DEN,
    S_GMM,
    S_NUMX,
    S_DIVX,
    S_NUMY,
    S_DIVY,
    S_ROW_END
  } state_e;

endpackage

@@ design/nbpg_mem.sv @@
`timescale 1ns / 1ps
// body store: one write port, one read port with registered data
// depends on nbpg_pkg

module nbpg_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AW-1:0]        waddr_i,
  input  nbpg_pkg::body_t      wdata_i,
  input  logic [AW-1:0]        raddr_i,
  output nbpg_pkg::body_t      rdata_o
);

  nbpg_pkg::body_t mem_q [DEPTH];
  nbpg_pkg::body_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/nbpg_mul.sv @@
`timescale 1ns / 1ps
// shared radix-2 shift-add multiplier, one bit of b per cycle
// depends on nbpg_pkg

module nbpg_mul (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [nbpg_pkg::MUL_A_W-1:0]  a_i,
  input  logic [nbpg_pkg::MUL_B_W-1:0]  b_i,
  output logic                          done_o,
  output logic [nbpg_pkg::MUL_P_W-1:0]  prod_o
);

  logic                           busy_q, busy_d;
  logic                           done_q, done_d;
  logic [nbpg_pkg::MUL_CNT_W-1:0] cnt_q, cnt_d;
  logic [nbpg_pkg::MUL_P_W-1:0]   acc_q, acc_d;
  logic [nbpg_pkg::MUL_P_W-1:0]   a_sh_q, a_sh_d;
  logic [nbpg_pkg::MUL_B_W-1:0]   b_sh_q, b_sh_d;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    a_sh_d = a_sh_q;
    b_sh_d = b_sh_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = nbpg_pkg::MUL_CNT_W'(nbpg_pkg::MUL_B_W);
      acc_d  = '0;
      a_sh_d = nbpg_pkg::MUL_P_W'(a_i);
      b_sh_d = b_i;
    end else if (busy_q) begin
      if (b_sh_q[0]) begin
        acc_d = acc_q + a_sh_q;
      end
      a_sh_d = a_sh_q << 1;
      b_sh_d = b_sh_q >> 1;
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == nbpg_pkg::MUL_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    a_sh_q <= a_sh_d;
    b_sh_q <= b_sh_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

@@ design/nbpg_sqrt.sv @@
`timescale 1ns / 1ps
// digit-by-digit integer square root, one root bit per cycle
// depends on nbpg_pkg

module nbpg_sqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [nbpg_pkg::R2_W-1:0]    rad_i,
  output logic                         done_o,
  output logic [nbpg_pkg::ROOT_W-1:0]  root_o
);

  logic                            busy_q, busy_d;
  logic                            done_q, done_d;
  logic [nbpg_pkg::SQ_CNT_W-1:0]   cnt_q, cnt_d;
  logic [nbpg_pkg::R2_W-1:0]       rad_q, rad_d;
  logic [nbpg_pkg::SQ_REM_W-1:0]   rem_q, rem_d;
  logic [nbpg_pkg::ROOT_W-1:0]     root_q, root_d;
  logic [nbpg_pkg::SQ_REM_W-1:0]   rem_sh, trial;
  logic                            ge;

  assign rem_sh = {rem_q[nbpg_pkg::SQ_REM_W-3:0],
                   rad_q[nbpg_pkg::R2_W-1:nbpg_pkg::R2_W-2]};
  assign trial  = nbpg_pkg::SQ_REM_W'({root_q, 2'b01});
  assign ge     = rem_sh >= trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = nbpg_pkg::SQ_CNT_W'(nbpg_pkg::ROOT_W);
      rad_d  = rad_i;
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q) begin
      rad_d  = rad_q << 2;
      rem_d  = ge ? (rem_sh - trial) : rem_sh;
      root_d = {root_q[nbpg_pkg::ROOT_W-2:0], ge};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == nbpg_pkg::SQ_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

@@ design/nbpg_div.sv @@
`timescale 1ns / 1ps
// restoring long divider of (num << 48) by den, one quotient bit per cycle
// depends on nbpg_pkg

module nbpg_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [nbpg_pkg::MUL_P_W-1:0] num_i,
  input  logic [nbpg_pkg::DEN_W-1:0]   den_i,
  output logic                         done_o,
  output logic [nbpg_pkg::QUO_W-1:0]   quo_o,
  output logic                         ovf_o
);

  logic                             busy_q, busy_d;
  logic                             done_q, done_d;
  logic [nbpg_pkg::DIV_CNT_W-1:0]   cnt_q, cnt_d;
  logic [nbpg_pkg::DIV_N_W-1:0]     nsh_q, nsh_d;
  logic [nbpg_pkg::DEN_W-1:0]       den_q, den_d;
  logic [nbpg_pkg::DEN_W-1:0]       rem_q, rem_d;
  logic [nbpg_pkg::QUO_W-1:0]       quo_q, quo_d;
  logic                             ovf_q, ovf_d;
  logic [nbpg_pkg::DEN_W:0]         rem_sh, rem_sub;
  logic                             ge;

  assign rem_sh  = {rem_q, nsh_q[nbpg_pkg::DIV_N_W-1]};
  assign ge      = rem_sh >= {1'b0, den_q};
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    nsh_d  = nsh_q;
    den_d  = den_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    ovf_d  = ovf_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = nbpg_pkg::DIV_CNT_W'(nbpg_pkg::DIV_N_W);
      nsh_d  = {num_i, {nbpg_pkg::FRAC_SHIFT{1'b0}}};
      den_d  = den_i;
      rem_d  = '0;
      quo_d  = '0;
      ovf_d  = 1'b0;
    end else if (busy_q) begin
      nsh_d = nsh_q << 1;
      rem_d = ge ? rem_sub[nbpg_pkg::DEN_W-1:0] : rem_sh[nbpg_pkg::DEN_W-1:0];
      // any quotient bit pushed past the top means the term clamps
      ovf_d = ovf_q | quo_q[nbpg_pkg::QUO_W-1];
      quo_d = {quo_q[nbpg_pkg::QUO_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == nbpg_pkg::DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nsh_q <= nsh_d;
    den_q <= den_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    ovf_q <= ovf_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign ovf_o  = ovf_q;

endmodule

@@ design/nbody_pairwise_gravity_force.sv @@
`timescale 1ns / 1ps
// operation: each body transfer stores one body; the closing body starts a pass that runs
//   every non-coincident pair through the shift-add multiplier, root and divider units
//   and skips self pairs and coincident pairs
// throughput: one set at a time; input stalls from the closing body until the last result
//   is in the output register
// reset: asynchronous, active low; clears control and the body count, gravity constant to 100

module nbody_pairwise_gravity_force #(
  parameter int unsigned MAX_POINTS = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [15:0]         gravity_constant_i,
  // body input channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic signed [31:0]  pos_x_i,
  input  logic signed [31:0]  pos_y_i,
  input  logic [31:0]         body_mass_i,
  input  logic                last_body_i,
  // force result channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [5:0]          body_index_o,
  output logic signed [63:0]  force_x_o,
  output logic signed [63:0]  force_y_o,
  output logic                coincident_o,
  output logic                saturated_o,
  output logic                last_result_o
);

  localparam int unsigned AW = $clog2(MAX_POINTS);
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);

  // ---------------------------------------------------------------------------
  // state
  // ---------------------------------------------------------------------------
  nbpg_pkg::state_e state_q, state_d;

  logic [CW-1:0]                  count_q, count_d;   // bodies stored in this set
  logic [CW-1:0]                  i_q, i_d;           // body whose force is formed
  logic [CW-1:0]                  j_q, j_d;           // partner body
  logic [nbpg_pkg::G_W-1:0]       g_q;

  logic [nbpg_pkg::POS_W-1:0]     xi_q, xi_d, yi_q, yi_d;
  logic [nbpg_pkg::MASS_W-1:0]    mj_q, mj_d;
  logic [nbpg_pkg::GMI_W-1:0]     gmi_q, gmi_d;
  logic [nbpg_pkg::GMM_W-1:0]     gmm_q, gmm_d;
  logic [nbpg_pkg::DIFF_W-1:0]    adx_q, adx_d, ady_q, ady_d;
  logic                           negx_q, negx_d, negy_q, negy_d;
  logic                           zero_q, zero_d;
  logic [nbpg_pkg::R2_W-1:0]      r2_q, r2_d;
  logic [nbpg_pkg::DEN_W-1:0]     den_q, den_d;
  logic [nbpg_pkg::FORCE_W-1:0]   fx_q, fx_d, fy_q, fy_d;
  logic                           coin_q, coin_d, sat_q, sat_d;

  // output register
  logic                           out_valid_q, out_valid_d;
  logic [nbpg_pkg::IDX_W-1:0]     out_idx_q, out_idx_d;
  logic [nbpg_pkg::FORCE_W-1:0]   out_fx_q, out_fx_d, out_fy_q, out_fy_d;
  logic                           out_coin_q, out_coin_d;
  logic                           out_sat_q, out_sat_d;
  logic                           out_last_q, out_last_d;

  // ---------------------------------------------------------------------------
  // handshakes
  // ---------------------------------------------------------------------------
  logic in_xfer, out_xfer, out_free, row_last;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != nbpg_pkg::S_LOAD);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_xfer    = out_valid_q && !out_stall_i;
  // result register can take the next force once the previous one has gone
  assign out_free    = !out_valid_q || !out_stall_i;
  assign row_last    = (CW'(i_q + 1'b1) == count_q);

  // ---------------------------------------------------------------------------
  // body store
  // ---------------------------------------------------------------------------
  logic            mem_we;
  logic [AW-1:0]   mem_raddr;
  nbpg_pkg::body_t mem_wdata, mem_rdata;

  assign mem_wdata.x    = pos_x_i;
  assign mem_wdata.y    = pos_y_i;
  assign mem_wdata.mass = body_mass_i;
  // row read fetches body i, every other read fetches a partner
  assign mem_raddr = (state_q == nbpg_pkg::S_ROW_RD) ? i_q[AW-1:0] : j_q[AW-1:0];

  nbpg_mem #(
    .DEPTH (MAX_POINTS),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // ---------------------------------------------------------------------------
  // shared arithmetic units
  // ---------------------------------------------------------------------------
  logic                          mul_start, mul_done;
  logic [nbpg_pkg::MUL_A_W-1:0]  mul_a;
  logic [nbpg_pkg::MUL_B_W-1:0]  mul_b;
  logic [nbpg_pkg::MUL_P_W-1:0]  mul_prod;
  logic                          sqrt_start, sqrt_done;
  logic [nbpg_pkg::ROOT_W-1:0]   sqrt_root;
  logic                          div_start, div_done, div_ovf;
  logic [nbpg_pkg::QUO_W-1:0]    div_quo;

  nbpg_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  nbpg_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (r2_q),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  // numerator is always the product just finished, divisor the stored r2 * root
  nbpg_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (mul_prod),
    .den_i   (den_q),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .ovf_o   (div_ovf)
  );

  // signed term from the divider, then saturating add into the running force
  function automatic nbpg_pkg::acc_t accumulate(
    input logic [nbpg_pkg::FORCE_W-1:0] acc,
    input logic [nbpg_pkg::QUO_W-1:0]   quo,
    input logic                         ovf,
    input logic                         neg
  );
    logic [nbpg_pkg::FORCE_W-1:0] term;
    logic [nbpg_pkg::FORCE_W:0]   sum;
    nbpg_pkg::acc_t               res;
    if (ovf) begin
      term = neg ? nbpg_pkg::FORCE_MIN : nbpg_pkg::FORCE_MAX;
    end else if (neg) begin
      term = -{1'b0, quo};
    end else begin
      term = {1'b0, quo};
    end
    sum       = {acc[nbpg_pkg::FORCE_W-1], acc} + {term[nbpg_pkg::FORCE_W-1], term};
    res.sat   = ovf;
    res.value = sum[nbpg_pkg::FORCE_W-1:0];
    if (sum[nbpg_pkg::FORCE_W] != sum[nbpg_pkg::FORCE_W-1]) begin
      res.sat   = 1'b1;
      res.value = sum[nbpg_pkg::FORCE_W] ? nbpg_pkg::FORCE_MIN : nbpg_pkg::FORCE_MAX;
    end
    return res;
  endfunction

  nbpg_pkg::acc_t acc_x, acc_y;
  assign acc_x = accumulate(fx_q, div_quo, div_ovf, negx_q);
  assign acc_y = accumulate(fy_q, div_quo, div_ovf, negy_q);

  // exact differences of the partner against body i
  logic [nbpg_pkg::DIFF_W-1:0] dx, dy;
  assign dx = {mem_rdata.x[nbpg_pkg::POS_W-1], mem_rdata.x} - {xi_q[nbpg_pkg::POS_W-1], xi_q};
  assign dy = {mem_rdata.y[nbpg_pkg::POS_W-1], mem_rdata.y} - {yi_q[nbpg_pkg::POS_W-1], yi_q};

  // ---------------------------------------------------------------------------
  // sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      nbpg_pkg::S_LOAD:      if (in_xfer && last_body_i) state_d = nbpg_pkg::S_ROW_RD;
      nbpg_pkg::S_ROW_RD:    state_d = nbpg_pkg::S_ROW_DATA;
      nbpg_pkg::S_ROW_DATA:  state_d = nbpg_pkg::S_GMI;
      nbpg_pkg::S_GMI:       if (mul_done) state_d = nbpg_pkg::S_PAIR_CHK;
      nbpg_pkg::S_PAIR_CHK: begin
        if (j_q == count_q) begin
          state_d = nbpg_pkg::S_ROW_END;
        end else if (j_q != i_q) begin
          state_d = nbpg_pkg::S_PAIR_DATA;
        end
      end
      nbpg_pkg::S_PAIR_DATA: state_d = nbpg_pkg::S_DIFF;
      nbpg_pkg::S_DIFF:      state_d = zero_q ? nbpg_pkg::S_PAIR_CHK : nbpg_pkg::S_SQX;
      nbpg_pkg::S_SQX:       if (mul_done) state_d = nbpg_pkg::S_SQY;
      nbpg_pkg::S_SQY:       if (mul_done) state_d = nbpg_pkg::S_SQRT_GO;
      nbpg_pkg::S_SQRT_GO:   state_d = nbpg_pkg::S_SQRT;
      nbpg_pkg::S_SQRT:      if (sqrt_done) state_d = nbpg_pkg::S_DEN;
      nbpg_pkg::S_DEN:       if (mul_done) state_d = nbpg_pkg::S_GMM;
      nbpg_pkg::S_GMM:       if (mul_done) state_d = nbpg_pkg::S_NUMX;
      nbpg_pkg::S_NUMX:      if (mul_done) state_d = nbpg_pkg::S_DIVX;
      nbpg_pkg::S_DIVX:      if (div_done) state_d = nbpg_pkg::S_NUMY;
      nbpg_pkg::S_NUMY:      if (mul_done) state_d = nbpg_pkg::S_DIVY;
      nbpg_pkg::S_DIVY:      if (div_done) state_d = nbpg_pkg::S_PAIR_CHK;
      nbpg_pkg::S_ROW_END: begin
        if (out_free) begin
          state_d = row_last ? nbpg_pkg::S_LOAD : nbpg_pkg::S_ROW_RD;
        end
      end
      default:               state_d = nbpg_pkg::S_LOAD;
    endcase
  end

  // ---------------------------------------------------------------------------
  // sequencer: datapath control and register updates
  // ---------------------------------------------------------------------------
  always_comb begin
    mem_we     = 1'b0;
    mul_start  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    sqrt_start = 1'b0;
    div_start  = 1'b0;

    count_d = count_q;
    i_d     = i_q;
    j_d     = j_q;
    xi_d    = xi_q;
    yi_d    = yi_q;
    mj_d    = mj_q;
    gmi_d   = gmi_q;
    gmm_d   = gmm_q;
    adx_d   = adx_q;
    ady_d   = ady_q;
    negx_d  = negx_q;
    negy_d  = negy_q;
    zero_d  = zero_q;
    r2_d    = r2_q;
    den_d   = den_q;
    fx_d    = fx_q;
    fy_d    = fy_q;
    coin_d  = coin_q;
    sat_d   = sat_q;

    out_valid_d = out_xfer ? 1'b0 : out_valid_q;
    out_idx_d   = out_idx_q;
    out_fx_d    = out_fx_q;
    out_fy_d    = out_fy_q;
    out_coin_d  = out_coin_q;
    out_sat_d   = out_sat_q;
    out_last_d  = out_last_q;

    unique case (state_q)
      nbpg_pkg::S_LOAD: begin
        if (in_xfer) begin
          // a body beyond the store is dropped, its closing flag still counts
          if (count_q < CW'(MAX_POINTS)) begin
            mem_we  = 1'b1;
            count_d = count_q + 1'b1;
          end
          if (last_body_i) begin
            i_d = '0;
          end
        end
      end
      nbpg_pkg::S_ROW_DATA: begin
        xi_d      = mem_rdata.x;
        yi_d      = mem_rdata.y;
        fx_d      = '0;
        fy_d      = '0;
        coin_d    = 1'b0;
        sat_d     = 1'b0;
        j_d       = '0;
        mul_start = 1'b1;
        mul_a     = nbpg_pkg::MUL_A_W'(mem_rdata.mass);
        mul_b     = nbpg_pkg::MUL_B_W'(g_q);
      end
      nbpg_pkg::S_GMI: begin
        if (mul_done) begin
          gmi_d = mul_prod[nbpg_pkg::GMI_W-1:0];
        end
      end
      nbpg_pkg::S_PAIR_CHK: begin
        // self pair is skipped without a read
        if (j_q != count_q && j_q == i_q) begin
          j_d = j_q + 1'b1;
        end
      end
      nbpg_pkg::S_PAIR_DATA: begin
        mj_d   = mem_rdata.mass;
        negx_d = dx[nbpg_pkg::DIFF_W-1];
        negy_d = dy[nbpg_pkg::DIFF_W-1];
        adx_d  = dx[nbpg_pkg::DIFF_W-1] ? (~dx + 1'b1) : dx;
        ady_d  = dy[nbpg_pkg::DIFF_W-1] ? (~dy + 1'b1) : dy;
        zero_d = (dx == '0) && (dy == '0);
      end
      nbpg_pkg::S_DIFF: begin
        if (zero_q) begin
          coin_d = 1'b1;
          j_d    = j_q + 1'b1;
        end else begin
          mul_start = 1'b1;
          mul_a     = nbpg_pkg::MUL_A_W'(adx_q);
          mul_b     = nbpg_pkg::MUL_B_W'(adx_q);
        end
      end
      nbpg_pkg::S_SQX: begin
        if (mul_done) begin
          r2_d      = mul_prod[nbpg_pkg::R2_W-1:0];
          mul_start = 1'b1;
          mul_a     = nbpg_pkg::MUL_A_W'(ady_q);
          mul_b     = nbpg_pkg::MUL_B_W'(ady_q);
        end
      end
      nbpg_pkg::S_SQY: begin
        if (mul_done) begin
          r2_d = r2_q + mul_prod[nbpg_pkg::R2_W-1:0];
        end
      end
      nbpg_pkg::S_SQRT_GO: begin
        sqrt_start = 1'b1;
      end
      nbpg_pkg::S_SQRT: begin
        if (sqrt_done) begin
          mul_start = 1'b1;
          mul_a     = nbpg_pkg::MUL_A_W'(r2_q);
          mul_b     = nbpg_pkg::MUL_B_W'(sqrt_root);
        end
      end
      nbpg_pkg::S_DEN: begin
        if (mul_done) begin
          den_d     = mul_prod[nbpg_pkg::DEN_W-1:0];
          mul_start = 1'b1;
          mul_a     = nbpg_pkg::MUL_A_W'(gmi_q);
          mul_b     = nbpg_pkg::MUL_B_W'(mj_q);
        end
      end
      nbpg_pkg::S_GMM: begin
        if (mul_done) begin
          gmm_d     = mul_prod[nbpg_pkg::GMM_W-1:0];
          mul_start = 1'b1;
          mul_a     = mul_prod[nbpg_pkg::GMM_W-1:0];
          mul_b     = nbpg_pkg::MUL_B_W'(adx_q);
        end
      end
      nbpg_pkg::S_NUMX: begin
        if (mul_done) begin
          div_start = 1'b1;
        end
      end
      nbpg_pkg::S_DIVX: begin
        if (div_done) begin
          fx_d      = acc_x.value;
          sat_d     = sat_q | acc_x.sat;
          mul_start = 1'b1;
          mul_a     = gmm_q;
          mul_b     = nbpg_pkg::MUL_B_W'(ady_q);
        end
      end
      nbpg_pkg::S_NUMY: begin
        if (mul_done) begin
          div_start = 1'b1;
        end
      end
      nbpg_pkg::S_DIVY: begin
        if (div_done) begin
          fy_d  = acc_y.value;
          sat_d = sat_q | acc_y.sat;
          j_d   = j_q + 1'b1;
        end
      end
      nbpg_pkg::S_ROW_END: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_idx_d   = nbpg_pkg::IDX_W'(i_q);
          out_fx_d    = fx_q;
          out_fy_d    = fy_q;
          out_coin_d  = coin_q;
          out_sat_d   = sat_q;
          out_last_d  = row_last;
          if (row_last) begin
            count_d = '0;
          end else begin
            i_d = i_q + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= nbpg_pkg::S_LOAD;
      count_q     <= '0;
      i_q         <= '0;
      j_q         <= '0;
      g_q         <= nbpg_pkg::G_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      i_q         <= i_d;
      j_q         <= j_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        g_q <= gravity_constant_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    xi_q       <= xi_d;
    yi_q       <= yi_d;
    mj_q       <= mj_d;
    gmi_q      <= gmi_d;
    gmm_q      <= gmm_d;
    adx_q      <= adx_d;
    ady_q      <= ady_d;
    negx_q     <= negx_d;
    negy_q     <= negy_d;
    zero_q     <= zero_d;
    r2_q       <= r2_d;
    den_q      <= den_d;
    fx_q       <= fx_d;
    fy_q       <= fy_d;
    coin_q     <= coin_d;
    sat_q      <= sat_d;
    out_idx_q  <= out_idx_d;
    out_fx_q   <= out_fx_d;
    out_fy_q   <= out_fy_d;
    out_coin_q <= out_coin_d;
    out_sat_q  <= out_sat_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign body_index_o  = out_idx_q;
  assign force_x_o     = out_fx_q;
  assign force_y_o     = out_fy_q;
  assign coincident_o  = out_coin_q;
  assign saturated_o   = out_sat_q;
  assign last_result_o = out_last_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_POINTS))
    else $error("body count beyond store depth");

  a_partner_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == nbpg_pkg::S_PAIR_DATA |-> (j_q != i_q) && (j_q < count_q))
    else $error("partner read addresses body i or an unwritten entry");

  a_mul_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == nbpg_pkg::S_GMI || state_q == nbpg_pkg::S_SQX ||
                  state_q == nbpg_pkg::S_SQY || state_q == nbpg_pkg::S_DEN ||
                  state_q == nbpg_pkg::S_GMM || state_q == nbpg_pkg::S_NUMX ||
                  state_q == nbpg_pkg::S_NUMY))
    else $error("multiplier finished with no step waiting for it");

  a_div_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == nbpg_pkg::S_DIVX || state_q == nbpg_pkg::S_DIVY))
    else $error("divider finished with no step waiting for it");

  a_set_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == nbpg_pkg::S_ROW_END && out_free && row_last)
      |=> (state_q == nbpg_pkg::S_LOAD && count_q == '0 && out_valid_q && out_last_q))
    else $error("set did not close after the final result");

endmodule
